FILE: design/pva_pkg.sv
package pva_pkg;

    // storage sizes
    localparam int STACK_DEPTH = 16;
    localparam int VOICE_COUNT = 8;

    // derived widths
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W  = $clog2(STACK_DEPTH);
    localparam int VCNT_W = $clog2(VOICE_COUNT + 1);
    localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    // fixed field widths
    localparam int NOTE_W    = 7;
    localparam int VOICE_W   = 3;
    localparam int LIMIT_W   = 4;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_SPAN   = 2'd2;

    // register reset values
    localparam logic [LIMIT_W-1:0] RST_VOICE_LIMIT = 4'd4;
    localparam logic [NOTE_W-1:0]  RST_NOTE_LOW    = 7'd36;
    localparam logic [NOTE_W-1:0]  RST_NOTE_SPAN   = 7'd61;

    // event kinds
    localparam logic CMD_NOTE_ON  = 1'b0;
    localparam logic CMD_NOTE_OFF = 1'b1;

    typedef logic [NOTE_W-1:0] note_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic edit;
        logic rel_step;
        logic asn_init;
        logic asn_step;
        logic out_load;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic rel_end;
        logic asn_end;
        logic out_free;
    } stat_t;

endpackage

FILE: design/poly_voice_allocator_unit.sv
// sequence: latch the input beat, edit the held stack, run the release walk over L
//   active voices (min of voice_limit and voice count), then the assign walk over W
//   held notes in the window after the stack edit, one voice and one window note per
//   cycle; the next event is taken only after the result reaches the output register
// reset: synchronous active-low aresetn empties the held stack, frees every voice and
//   loads voice_limit 4, note_low 36, note_span 61; no clearing pass
module poly_voice_allocator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // event input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [pva_pkg::NOTE_W-1:0]    s_pitch,
    // register writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pva_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pva_pkg::NOTE_W-1:0]    cfg_data,
    // result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_freed_valid,
    output logic [pva_pkg::VOICE_W-1:0]   m_freed_voice,
    output logic                          m_assigned_valid,
    output logic [pva_pkg::VOICE_W-1:0]   m_assigned_voice,
    output logic [pva_pkg::NOTE_W-1:0]    m_assigned_pitch
);

    pva_pkg::ctl_t  ctl;
    pva_pkg::stat_t st;

    // register writes take effect in the next cycle and are always taken
    assign cfg_ready = 1'b1;

    // sequencer: accept, edit stack, release walk, assign walk, hand off to output
    pva_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .ctl     (ctl)
    );

    // held stack, voice table, config registers and the output register;
    // a finished result waits in the output register while the next beat is taken
    pva_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_cmd            (s_cmd),
        .s_pitch          (s_pitch),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .ctl              (ctl),
        .st               (st),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_freed_valid    (m_freed_valid),
        .m_freed_voice    (m_freed_voice),
        .m_assigned_valid (m_assigned_valid),
        .m_assigned_voice (m_assigned_voice),
        .m_assigned_pitch (m_assigned_pitch)
    );

endmodule

FILE: design/pva_ctrl.sv
module pva_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pva_pkg::stat_t st,
    output pva_pkg::ctl_t  ctl
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EDIT = 3'd1;
    localparam logic [2:0] ST_REL  = 3'd2;
    localparam logic [2:0] ST_ASN  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.load   = 1'b1;
                    state_next = ST_EDIT;
                end
            end
            ST_EDIT: begin
                ctl.edit   = 1'b1;
                state_next = ST_REL;
            end
            ST_REL: begin
                if (st.rel_end) begin
                    ctl.asn_init = 1'b1;
                    state_next   = ST_ASN;
                end else begin
                    ctl.rel_step = 1'b1;
                end
            end
            ST_ASN: begin
                if (st.asn_end) begin
                    state_next = ST_DONE;
                end else begin
                    ctl.asn_step = 1'b1;
                end
            end
            ST_DONE: begin
                if (st.out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/pva_datapath.sv
module pva_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_cmd,
    input  logic [pva_pkg::NOTE_W-1:0]       s_pitch,
    input  logic                             cfg_valid,
    input  logic [pva_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pva_pkg::NOTE_W-1:0]       cfg_data,
    input  pva_pkg::ctl_t                    ctl,
    output pva_pkg::stat_t                   st,
    input  logic                             m_ready,
    output logic                             m_valid,
    output logic                             m_freed_valid,
    output logic [pva_pkg::VOICE_W-1:0]      m_freed_voice,
    output logic                             m_assigned_valid,
    output logic [pva_pkg::VOICE_W-1:0]      m_assigned_voice,
    output logic [pva_pkg::NOTE_W-1:0]       m_assigned_pitch
);

    localparam int DEPTH  = pva_pkg::STACK_DEPTH;
    localparam int VCOUNT = pva_pkg::VOICE_COUNT;
    localparam int CNT_W  = pva_pkg::CNT_W;
    localparam int IDX_W  = pva_pkg::IDX_W;
    localparam int VCNT_W = pva_pkg::VCNT_W;
    localparam int VIDX_W = pva_pkg::VIDX_W;
    localparam int VOICE_W = pva_pkg::VOICE_W;
    localparam int NOTE_W = pva_pkg::NOTE_W;

    // configuration
    logic [pva_pkg::LIMIT_W-1:0] voice_limit_reg;
    pva_pkg::note_t              note_low_reg;
    pva_pkg::note_t              note_span_reg;

    // event latch
    logic           cmd_reg;
    pva_pkg::note_t pitch_reg;

    // held stack and voices
    pva_pkg::note_t    held_reg   [DEPTH];
    pva_pkg::note_t    held_next  [DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    pva_pkg::note_t    voice_reg  [VCOUNT];
    pva_pkg::note_t    voice_next [VCOUNT];

    // walk counters
    logic [VCNT_W-1:0] v_reg;
    logic [CNT_W-1:0]  i_reg;

    // per-event results
    logic               freed_valid_reg;
    logic [VOICE_W-1:0] freed_voice_reg;
    logic               asg_valid_reg;
    logic [VOICE_W-1:0] asg_voice_reg;
    pva_pkg::note_t     asg_pitch_reg;

    // output register
    logic               m_valid_reg;
    logic               m_freed_valid_reg;
    logic [VOICE_W-1:0] m_freed_voice_reg;
    logic               m_asg_valid_reg;
    logic [VOICE_W-1:0] m_asg_voice_reg;
    pva_pkg::note_t     m_asg_pitch_reg;

    logic [VCNT_W-1:0] lim;
    logic [CNT_W-1:0]  first;
    logic [NOTE_W:0]   range_top;
    logic              in_range;
    logic              found;
    logic [IDX_W-1:0]  pos;
    logic [VIDX_W-1:0] vv;
    pva_pkg::note_t    cur_voice;
    logic              keep;
    logic              rel_free;
    pva_pkg::note_t    cur_note;
    logic              playing;
    logic              free_found;
    logic [VIDX_W-1:0] free_idx;
    logic              asn_hit;

    // active voices and window start
    always_comb begin
        if (32'(voice_limit_reg) > VCOUNT) begin
            lim = VCNT_W'(VCOUNT);
        end else begin
            lim = VCNT_W'(voice_limit_reg);
        end
        if (32'(count_reg) > 32'(lim)) begin
            first = CNT_W'(32'(count_reg) - 32'(lim));
        end else begin
            first = '0;
        end
    end

    // stack edit
    always_comb begin
        range_top  = {1'b0, note_low_reg} + {1'b0, note_span_reg};
        in_range   = (pitch_reg >= note_low_reg) && ({1'b0, pitch_reg} < range_top);
        found      = 1'b0;
        pos        = '0;
        held_next  = held_reg;
        count_next = count_reg;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (32'(k) < 32'(count_reg) && held_reg[IDX_W'(k)] == pitch_reg) begin
                found = 1'b1;
                pos   = IDX_W'(k);
            end
        end
        if (in_range) begin
            if (cmd_reg == pva_pkg::CMD_NOTE_ON && !found) begin
                if (32'(count_reg) < DEPTH) begin
                    held_next[count_reg[IDX_W-1:0]] = pitch_reg;
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    // full: drop the oldest
                    for (int k = 0; k < DEPTH - 1; k++) begin
                        held_next[IDX_W'(k)] = held_reg[IDX_W'(k + 1)];
                    end
                    held_next[IDX_W'(DEPTH - 1)] = pitch_reg;
                end
            end else if (cmd_reg == pva_pkg::CMD_NOTE_OFF && found) begin
                for (int k = 0; k < DEPTH - 1; k++) begin
                    if (IDX_W'(k) >= pos) begin
                        held_next[IDX_W'(k)] = held_reg[IDX_W'(k + 1)];
                    end
                end
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    // release step: one voice against the whole window
    always_comb begin
        vv        = v_reg[VIDX_W-1:0];
        cur_voice = voice_reg[vv];
        keep      = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
            if (32'(k) >= 32'(first) && 32'(k) < 32'(count_reg)
                && held_reg[IDX_W'(k)] == cur_voice) begin
                keep = 1'b1;
            end
        end
        rel_free = (cur_voice != '0) && !keep;
    end

    // assign step: one window note against all active voices
    always_comb begin
        cur_note   = held_reg[i_reg[IDX_W-1:0]];
        playing    = 1'b0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int v = VCOUNT - 1; v >= 0; v--) begin
            if (32'(v) < 32'(lim)) begin
                if (voice_reg[VIDX_W'(v)] == cur_note) begin
                    playing = 1'b1;
                end
                if (voice_reg[VIDX_W'(v)] == '0) begin
                    free_found = 1'b1;
                    free_idx   = VIDX_W'(v);
                end
            end
        end
        asn_hit = !playing && free_found;
    end

    always_comb begin
        voice_next = voice_reg;
        if (ctl.rel_step && rel_free) begin
            voice_next[vv] = '0;
        end
        if (ctl.asn_step && asn_hit) begin
            voice_next[free_idx] = cur_note;
        end
    end

    assign st.rel_end  = (v_reg >= lim);
    assign st.asn_end  = (i_reg >= count_reg);
    assign st.out_free = !m_valid_reg || m_ready;

    // control state and voices
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voice_limit_reg <= pva_pkg::RST_VOICE_LIMIT;
            note_low_reg    <= pva_pkg::RST_NOTE_LOW;
            note_span_reg   <= pva_pkg::RST_NOTE_SPAN;
            count_reg       <= '0;
            voice_reg       <= '{default: '0};
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    pva_pkg::CFG_VOICE_LIMIT: voice_limit_reg <= cfg_data[pva_pkg::LIMIT_W-1:0];
                    pva_pkg::CFG_NOTE_LOW:    note_low_reg    <= cfg_data;
                    pva_pkg::CFG_NOTE_SPAN:   note_span_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (ctl.edit) begin
                count_reg <= count_next;
            end
            voice_reg <= voice_next;
            if (ctl.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (ctl.edit) begin
            held_reg <= held_next;
        end
        if (ctl.load) begin
            cmd_reg         <= s_cmd;
            pitch_reg       <= s_pitch;
            v_reg           <= '0;
            freed_valid_reg <= 1'b0;
            freed_voice_reg <= '0;
            asg_valid_reg   <= 1'b0;
            asg_voice_reg   <= '0;
            asg_pitch_reg   <= '0;
        end
        if (ctl.rel_step) begin
            v_reg <= v_reg + VCNT_W'(1);
            if (rel_free) begin
                freed_valid_reg <= 1'b1;
                freed_voice_reg <= VOICE_W'(v_reg);
            end
        end
        if (ctl.asn_init) begin
            i_reg <= first;
        end
        if (ctl.asn_step) begin
            i_reg <= i_reg + CNT_W'(1);
            if (asn_hit) begin
                asg_valid_reg <= 1'b1;
                asg_voice_reg <= VOICE_W'(free_idx);
                asg_pitch_reg <= cur_note;
            end
        end
        if (ctl.out_load) begin
            m_freed_valid_reg <= freed_valid_reg;
            m_freed_voice_reg <= freed_voice_reg;
            m_asg_valid_reg   <= asg_valid_reg;
            m_asg_voice_reg   <= asg_voice_reg;
            m_asg_pitch_reg   <= asg_pitch_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_freed_valid    = m_freed_valid_reg;
    assign m_freed_voice    = m_freed_voice_reg;
    assign m_assigned_valid = m_asg_valid_reg;
    assign m_assigned_voice = m_asg_voice_reg;
    assign m_assigned_pitch = m_asg_pitch_reg;

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.edit |=> (count_reg == $past(count_reg)
                      || count_reg == $past(count_reg) + CNT_W'(1)
                      || count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("held count moved by more than one");

    a_asn_in_stack: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.asn_step |-> (i_reg < count_reg))
        else $error("assign walk beyond held notes");

    a_freed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_freed_valid_reg) |-> (m_freed_voice_reg == '0))
        else $error("freed voice nonzero without release");

    a_asg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_asg_valid_reg)
            |-> (m_asg_voice_reg == '0 && m_asg_pitch_reg == '0))
        else $error("assigned fields nonzero without assignment");

    a_asg_pitch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_asg_valid_reg) |-> (m_asg_pitch_reg != '0))
        else $error("voice assigned a free marker");

endmodule
